### hdl/cda_pkg.sv
// Shared types, constants and calendar functions for the date advance unit.
package cda_pkg;

	localparam int INC_BITS_DEF = 16;

	localparam logic [1:0] CMD_SET        = 2'd0;
	localparam logic [1:0] CMD_ADD_DAYS   = 2'd1;
	localparam logic [1:0] CMD_ADD_MONTHS = 2'd2;
	localparam logic [1:0] CMD_ADD_YEARS  = 2'd3;

	localparam logic [15:0] RESET_YEAR  = 16'd2012;
	localparam logic [3:0]  RESET_MONTH = 4'd7;
	localparam logic [4:0]  RESET_DAY   = 5'd12;

	localparam logic [3:0] MONTH_FIRST = 4'd1;
	localparam logic [3:0] MONTH_FEB   = 4'd2;
	localparam logic [3:0] MONTH_LAST  = 4'd12;
	localparam logic [4:0] DAY_FIRST   = 5'd1;

	localparam logic [4:0] FEB_DAYS_LEAP   = 5'd29;
	localparam logic [4:0] FEB_DAYS_COMMON = 5'd28;
	localparam logic [8:0] YEAR_DAYS_LEAP   = 9'd366;
	localparam logic [8:0] YEAR_DAYS_COMMON = 9'd365;

	localparam logic [4:0] MONTH_DAYS [12] = '{
		5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
		5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
	};

	// inverse of 25 modulo 2^14 and the divisibility bound (2^14 - 1) / 25
	localparam logic [13:0] INV25_14   = 14'd7209;
	localparam logic [13:0] DIV25_BOUND = 14'd655;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DAYS,
		ST_YEARS,
		ST_DIV,
		ST_MFIN,
		ST_WB
	} state_t;

	typedef enum logic [1:0] {
		ALU_DAY,
		ALU_YEAR,
		ALU_DIV
	} alu_sel_t;

	typedef struct packed {
		alu_sel_t alu_sel;
		logic     load;
		logic     day_step;
		logic     year_step;
		logic     div_step;
		logic     mon_fin;
		logic     wb;
	} ctl_t;

	typedef struct packed {
		logic borrow;
		logic div_last;
		logic out_busy;
	} sts_t;

	function automatic logic cda_is_leap(input logic [15:0] y);
		logic [13:0] p4;
		logic [13:0] p16;
		logic        d100;
		logic        d400;
		p4   = 14'(y[15:2] * INV25_14);
		p16  = 14'({2'b00, y[15:4]} * INV25_14);
		d100 = (y[1:0] == 2'b00) && (p4 <= DIV25_BOUND);
		d400 = (y[3:0] == 4'b0000) && (p16 <= DIV25_BOUND);
		return (y[1:0] == 2'b00) && (!d100 || d400);
	endfunction

	function automatic logic [4:0] cda_month_len(input logic [15:0] y, input logic [3:0] m);
		logic [4:0] len;
		if (m < MONTH_FIRST || m > MONTH_LAST) begin
			len = MONTH_DAYS[0];
		end else if (m == MONTH_FEB) begin
			len = cda_is_leap(y) ? FEB_DAYS_LEAP : FEB_DAYS_COMMON;
		end else begin
			len = MONTH_DAYS[m - MONTH_FIRST];
		end
		return len;
	endfunction

endpackage

### hdl/cda_alu.sv
// Shared subtract and compare unit.
module cda_alu
	import cda_pkg::*;
#(
	parameter int W = INC_BITS_DEF + 1
) (
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	output logic [W-1:0] diff,
	output logic         borrow
);

	logic [W:0] full;

	assign full   = {1'b0, a} - {1'b0, b};
	assign diff   = full[W-1:0];
	assign borrow = full[W];

endmodule

### hdl/cda_ctrl.sv
// Sequencer for the date advance unit.
module cda_ctrl
	import cda_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [1:0] command,
	input  sts_t       sts,
	output logic       in_stall,
	output ctl_t       ctl
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					unique case (command) inside
						CMD_SET, CMD_ADD_YEARS: state_d = ST_WB;
						CMD_ADD_DAYS:           state_d = ST_DAYS;
						CMD_ADD_MONTHS:         state_d = ST_DIV;
						default:                state_d = ST_WB;
					endcase
				end
			end
			ST_DAYS: begin
				state_d = sts.borrow ? ST_WB : ST_YEARS;
			end
			ST_YEARS: begin
				if (sts.borrow) begin
					state_d = ST_DAYS;
				end
			end
			ST_DIV: begin
				if (sts.div_last) begin
					state_d = ST_MFIN;
				end
			end
			ST_MFIN: begin
				state_d = ST_WB;
			end
			ST_WB: begin
				if (!sts.out_busy) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctl          = '0;
		ctl.alu_sel  = ALU_DAY;
		in_stall     = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				ctl.load = in_valid;
			end
			ST_DAYS: begin
				ctl.day_step = 1'b1;
			end
			ST_YEARS: begin
				ctl.alu_sel   = ALU_YEAR;
				ctl.year_step = 1'b1;
			end
			ST_DIV: begin
				ctl.alu_sel  = ALU_DIV;
				ctl.div_step = 1'b1;
			end
			ST_MFIN: begin
				ctl.mon_fin = 1'b1;
			end
			ST_WB: begin
				ctl.wb = !sts.out_busy;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

endmodule

### hdl/cda_dp.sv
// Date registers, work registers and result register of the date advance unit.
module cda_dp
	import cda_pkg::*;
#(
	parameter int INC_BITS = INC_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ctl_t                ctl,
	input  logic [1:0]          command,
	input  logic [15:0]         set_year,
	input  logic [3:0]          set_month,
	input  logic [4:0]          set_day,
	input  logic [INC_BITS-1:0] increment,
	input  logic                out_stall,
	output sts_t                sts,
	output logic                out_valid,
	output logic [15:0]         out_year,
	output logic [3:0]          out_month,
	output logic [4:0]          out_day
);

	localparam int RW = INC_BITS + 1;
	localparam int CW = $clog2(RW);

	logic [15:0]   year_q;
	logic [3:0]    month_q;
	logic [4:0]    day_q;
	logic [RW-1:0] rem_q;
	logic [3:0]    part_q;
	logic [CW-1:0] cnt_q;
	logic          out_valid_q;
	logic [15:0]   out_year_q;
	logic [3:0]    out_month_q;
	logic [4:0]    out_day_q;

	logic [RW-1:0]        alu_a;
	logic [RW-1:0]        alu_b;
	logic [RW-1:0]        alu_diff;
	logic                 alu_borrow;
	logic [4:0]           len;
	logic [15:0]          span_year;
	logic [8:0]           span;
	logic [4:0]           part_shift;
	logic [INC_BITS+15:0] inc_x;
	logic [RW+15:0]       quo_x;
	logic [3:0]           set_month_c;
	logic [4:0]           set_day_c;

	assign len        = cda_month_len(year_q, month_q);
	assign span_year  = (month_q <= MONTH_FEB) ? year_q : year_q + 16'd1;
	assign span       = cda_is_leap(span_year) ? YEAR_DAYS_LEAP : YEAR_DAYS_COMMON;
	assign part_shift = {part_q, rem_q[RW-1]};
	assign inc_x      = {16'd0, increment};
	assign quo_x      = {16'd0, rem_q};

	always_comb begin
		if (set_month < MONTH_FIRST) begin
			set_month_c = MONTH_FIRST;
		end else if (set_month > MONTH_LAST) begin
			set_month_c = MONTH_LAST;
		end else begin
			set_month_c = set_month;
		end
		set_day_c = (set_day < DAY_FIRST) ? DAY_FIRST : set_day;
	end

	always_comb begin
		case (ctl.alu_sel)
			ALU_YEAR: begin
				alu_a = rem_q;
				alu_b = RW'(span);
			end
			ALU_DIV: begin
				alu_a = RW'(part_shift);
				alu_b = RW'(MONTH_LAST);
			end
			default: begin
				alu_a = rem_q + RW'(day_q);
				alu_b = RW'(len) + RW'(1);
			end
		endcase
	end

	cda_alu #(
		.W(RW)
	) u_alu (
		.a      (alu_a),
		.b      (alu_b),
		.diff   (alu_diff),
		.borrow (alu_borrow)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			year_q  <= RESET_YEAR;
			month_q <= RESET_MONTH;
			day_q   <= RESET_DAY;
			rem_q   <= '0;
			part_q  <= '0;
			cnt_q   <= '0;
		end else begin
			if (ctl.load) begin
				case (command)
					CMD_SET: begin
						year_q  <= set_year;
						month_q <= set_month_c;
						day_q   <= set_day_c;
					end
					CMD_ADD_DAYS: begin
						rem_q <= RW'(increment);
					end
					CMD_ADD_MONTHS: begin
						rem_q  <= RW'(month_q - MONTH_FIRST) + RW'(increment);
						part_q <= '0;
						cnt_q  <= '0;
					end
					default: begin
						year_q <= year_q + inc_x[15:0];
					end
				endcase
			end
			if (ctl.day_step) begin
				if (alu_borrow) begin
					day_q <= alu_a[4:0];
				end else begin
					rem_q <= alu_diff;
					day_q <= DAY_FIRST;
					if (month_q == MONTH_LAST) begin
						month_q <= MONTH_FIRST;
						year_q  <= year_q + 16'd1;
					end else begin
						month_q <= month_q + 4'd1;
					end
				end
			end
			if (ctl.year_step && !alu_borrow) begin
				rem_q  <= alu_diff;
				year_q <= year_q + 16'd1;
			end
			if (ctl.div_step) begin
				part_q <= alu_borrow ? part_shift[3:0] : alu_diff[3:0];
				rem_q  <= {rem_q[RW-2:0], !alu_borrow};
				cnt_q  <= cnt_q + CW'(1);
			end
			if (ctl.mon_fin) begin
				year_q  <= year_q + quo_x[15:0];
				month_q <= part_q + MONTH_FIRST;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.wb) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.wb) begin
			out_year_q  <= year_q;
			out_month_q <= month_q;
			out_day_q   <= day_q;
		end
	end

	assign sts.borrow   = alu_borrow;
	assign sts.div_last = (cnt_q == CW'(RW - 1));
	assign sts.out_busy = out_valid_q && out_stall;

	assign out_valid = out_valid_q;
	assign out_year  = out_year_q;
	assign out_month = out_month_q;
	assign out_day   = out_day_q;

endmodule

### hdl/calendar_date_advance.sv
// Top level of the calendar date advance unit.
//
//   channel   direction   handshake            payload
//   request   in          in_valid, in_stall   command, set_year, set_month, set_day, increment
//   result    out         out_valid, out_stall out_year, out_month, out_day
//
// Set and add years go from accept straight to writeback. Add months: a long division
// of the month offset by 12, one quotient bit per cycle through the shared subtractor,
// then month fix-up and writeback. Add days: month steps and whole-year skips, then writeback.
// Reset loads 2012-07-12 and clears the result valid. in_stall is high while a
// request is at work; a stalled result holds the unit before it returns to idle.
module calendar_date_advance
	import cda_pkg::*;
#(
	parameter int INC_BITS = INC_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          command,
	input  logic [15:0]         set_year,
	input  logic [3:0]          set_month,
	input  logic [4:0]          set_day,
	input  logic [INC_BITS-1:0] increment,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [15:0]         out_year,
	output logic [3:0]          out_month,
	output logic [4:0]          out_day
);

	ctl_t ctl;
	sts_t sts;

	cda_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.command  (command),
		.sts      (sts),
		.in_stall (in_stall),
		.ctl      (ctl)
	);

	cda_dp #(
		.INC_BITS(INC_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.command   (command),
		.set_year  (set_year),
		.set_month (set_month),
		.set_day   (set_day),
		.increment (increment),
		.out_stall (out_stall),
		.sts       (sts),
		.out_valid (out_valid),
		.out_year  (out_year),
		.out_month (out_month),
		.out_day   (out_day)
	);

endmodule
